// ===== rtl/core/pxe_pkg.sv =====
// Shared types, codes and arithmetic helpers for the prefix expression evaluator.
package pxe_pkg;

  localparam int VALUE_DEPTH_DEF = 64;
  localparam int OP_DEPTH_DEF    = 64;
  localparam int RESULT_LIMIT    = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int FRAC_BITS       = 16;
  localparam int DIV_NUM_W       = 32 + FRAC_BITS;
  localparam int DIV_STEPS       = DIV_NUM_W;

  // token kinds
  localparam logic [1:0] TOK_NUM = 2'd0;
  localparam logic [1:0] TOK_OP  = 2'd1;
  localparam logic [1:0] TOK_EOL = 2'd2;
  localparam logic [1:0] TOK_UNK = 2'd3;

  // operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_VALUE   = 3'd0;
  localparam logic [2:0] KIND_ZERODIV = 3'd1;
  localparam logic [2:0] KIND_UNKNOWN = 3'd2;
  localparam logic [2:0] KIND_EMPTY   = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         tok;
    logic [1:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  // saturate a 33-bit sum to 32 bits
  function automatic logic signed [31:0] sat_sum(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? Q_MIN : Q_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // product / 2^16 rounded toward zero, saturated
  function automatic logic signed [31:0] mul_scale(input logic signed [63:0] p);
    logic signed [63:0] adj;
    logic signed [63:0] q;
    logic signed [31:0] r;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    q   = adj >>> FRAC_BITS;
    if (q > 64'sd2147483647) begin
      r = Q_MAX;
    end else if (q < -64'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = q[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pxe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pxe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pxe_div.sv =====
// Radix-2 restoring divider for (a * 2^16) / b, truncating toward zero, saturated.
module pxe_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] quo
);
  import pxe_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [31:0]          rem;
  logic [DIV_NUM_W-1:0] qr;
  logic [31:0]          den;
  logic                 neg;
  logic [32:0]          rem_sh;
  logic                 ge;
  logic [31:0]          amag;
  logic [31:0]          bmag;

  assign amag   = a[31] ? 32'(32'd0 - a) : a;
  assign bmag   = b[31] ? 32'(32'd0 - b) : b;
  assign rem_sh = {rem, qr[DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qr  <= {amag, {FRAC_BITS{1'b0}}};
      den <= bmag;
      neg <= a[31] ^ b[31];
    end else if (busy) begin
      rem <= ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
      qr  <= {qr[DIV_NUM_W-2:0], ge};
    end
  end

  always_comb begin
    if (neg) begin
      quo = (qr > DIV_NUM_W'(64'd2147483648)) ? Q_MIN : 32'(32'd0 - qr[31:0]);
    end else begin
      quo = (qr > DIV_NUM_W'(64'd2147483647)) ? Q_MAX : qr[31:0];
    end
  end

endmodule

// ===== rtl/core/pxe_front.sv =====
// Input stage: takes tokens, classifies them into commands for the queue.
module pxe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [1:0]         operator_code,
  input  logic signed [31:0] number_value,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output pxe_pkg::cmd_t      cmd
);
  import pxe_pkg::*;

  logic stage_valid;
  cmd_t stage_cmd;
  cmd_t cls;

  always_comb begin
    cls.tok   = req_type;
    cls.op    = '0;
    cls.value = '0;
    case (req_type)
      TOK_NUM: cls.value = number_value;
      TOK_OP:  cls.op    = operator_code;
      default: begin
      end
    endcase
  end

  assign in_ready  = !stage_valid || cmd_ready;
  assign cmd_valid = stage_valid;
  assign cmd       = stage_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_cmd <= cls;
    end
  end

endmodule

// ===== rtl/core/pxe_queue.sv =====
// Small command FIFO between the front and back ends.
module pxe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  pxe_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pxe_pkg::cmd_t rd_data
);
  import pxe_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = count != (AW + 1)'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/pxe_back.sv =====
// Execution sequencer: value and operator stacks, reductions, result output.
module pxe_back #(
  parameter int VALUE_DEPTH = pxe_pkg::VALUE_DEPTH_DEF,
  parameter int OP_DEPTH    = pxe_pkg::OP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pxe_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         result_kind,
  output logic signed [31:0] result_value,
  output logic               last_of_run
);
  import pxe_pkg::*;

  localparam int VCW = $clog2(VALUE_DEPTH + 1);
  localparam int VAW = $clog2(VALUE_DEPTH);
  localparam int OCW = $clog2(OP_DEPTH + 1);
  localparam int OAW = $clog2(OP_DEPTH);
  localparam int OW  = 2 + VCW;
  localparam int ECW = $clog2(RESULT_LIMIT + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EOL    = 4'd1;
  localparam logic [3:0] ST_REDUCE = 4'd2;
  localparam logic [3:0] ST_OPRD   = 4'd3;
  localparam logic [3:0] ST_RDB    = 4'd4;
  localparam logic [3:0] ST_RDA    = 4'd5;
  localparam logic [3:0] ST_EXEC   = 4'd6;
  localparam logic [3:0] ST_MUL    = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_FINISH = 4'd9;

  logic [3:0]         state, state_next;
  logic [VCW-1:0]     vcount, vcount_next;
  logic [OCW-1:0]     ocount, ocount_next;
  logic [1:0]         op_reg, op_reg_next;
  logic signed [31:0] a_reg, a_reg_next;
  logic signed [31:0] b_reg, b_reg_next;
  logic signed [63:0] prod, prod_next;
  logic               held_valid, held_valid_next;
  logic [2:0]         held_kind, held_kind_next;
  logic signed [31:0] held_value, held_value_next;
  logic [ECW-1:0]     emit_cnt, emit_cnt_next;
  logic               out_valid_next;
  logic [2:0]         result_kind_next;
  logic signed [31:0] result_value_next;
  logic               last_of_run_next;

  logic [VCW-1:0] vcount_m1;
  logic [VCW-1:0] vcount_m2;
  logic [OCW-1:0] ocount_m1;

  logic           v_we;
  logic [VAW-1:0] v_waddr;
  logic [31:0]    v_wdata;
  logic [VAW-1:0] v_raddr;
  logic [31:0]    v_rdata;
  logic           o_we;
  logic [OAW-1:0] o_waddr;
  logic [OW-1:0]  o_wdata;
  logic [OAW-1:0] o_raddr;
  logic [OW-1:0]  o_rdata;
  logic [1:0]     rd_op;
  logic [VCW-1:0] rd_mark;
  logic           reduce_ok;

  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quo;

  logic               emit_req;
  logic [2:0]         emit_kind;
  logic signed [31:0] emit_value;
  logic               under_limit;
  logic               out_free;
  logic               emit_stall;
  logic               push;
  logic               push_last;

  pxe_ram #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  pxe_ram #(.WIDTH(OW), .DEPTH(OP_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  pxe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (a_reg),
    .b     (b_reg),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign vcount_m1   = vcount - 1'b1;
  assign vcount_m2   = vcount - VCW'(2);
  assign ocount_m1   = ocount - 1'b1;
  assign rd_op       = o_rdata[OW-1:VCW];
  assign rd_mark     = o_rdata[VCW-1:0];
  assign reduce_ok   = ({1'b0, rd_mark} + (VCW + 1)'(2)) <= {1'b0, vcount};
  assign under_limit = emit_cnt < ECW'(RESULT_LIMIT);
  assign out_free    = !out_valid || out_ready;
  // a second result can only be produced once the held one has somewhere to go
  assign emit_stall  = emit_req && held_valid && !out_free && under_limit;

  always_comb begin
    state_next        = state;
    vcount_next       = vcount;
    ocount_next       = ocount;
    op_reg_next       = op_reg;
    a_reg_next        = a_reg;
    b_reg_next        = b_reg;
    prod_next         = prod;
    held_valid_next   = held_valid;
    held_kind_next    = held_kind;
    held_value_next   = held_value;
    emit_cnt_next     = emit_cnt;
    out_valid_next    = out_valid;
    result_kind_next  = result_kind;
    result_value_next = result_value;
    last_of_run_next  = last_of_run;

    cmd_ready  = 1'b0;
    v_we       = 1'b0;
    v_waddr    = vcount[VAW-1:0];
    v_wdata    = cmd.value;
    v_raddr    = vcount_m1[VAW-1:0];
    o_we       = 1'b0;
    o_waddr    = ocount[OAW-1:0];
    o_wdata    = {cmd.op, vcount};
    o_raddr    = ocount_m1[OAW-1:0];
    div_start  = 1'b0;
    emit_req   = 1'b0;
    emit_kind  = KIND_VALUE;
    emit_value = '0;
    push       = 1'b0;
    push_last  = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          case (cmd.tok)
            TOK_NUM: begin
              if (vcount == VCW'(VALUE_DEPTH)) begin
                emit_req  = 1'b1;
                emit_kind = KIND_FULL;
              end else begin
                v_we        = 1'b1;
                vcount_next = vcount + 1'b1;
              end
              state_next = ST_REDUCE;
            end
            TOK_OP: begin
              if (ocount == OCW'(OP_DEPTH)) begin
                emit_req  = 1'b1;
                emit_kind = KIND_FULL;
              end else begin
                o_we        = 1'b1;
                ocount_next = ocount + 1'b1;
              end
              state_next = ST_FINISH;
            end
            TOK_EOL: begin
              if (vcount == '0) begin
                emit_req   = 1'b1;
                emit_kind  = KIND_EMPTY;
                state_next = ST_FINISH;
              end else begin
                vcount_next = vcount_m1;
                state_next  = ST_EOL;
              end
            end
            default: begin
              emit_req   = 1'b1;
              emit_kind  = KIND_UNKNOWN;
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_EOL: begin
        emit_req   = 1'b1;
        emit_kind  = KIND_VALUE;
        emit_value = v_rdata;
        state_next = ST_FINISH;
      end
      ST_REDUCE: begin
        state_next = (ocount == '0) ? ST_FINISH : ST_OPRD;
      end
      ST_OPRD: begin
        if (reduce_ok) begin
          op_reg_next = rd_op;
          state_next  = ST_RDB;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_RDB: begin
        b_reg_next = v_rdata;
        v_raddr    = vcount_m2[VAW-1:0];
        state_next = ST_RDA;
      end
      ST_RDA: begin
        a_reg_next = v_rdata;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        v_waddr = vcount_m2[VAW-1:0];
        case (op_reg)
          OP_ADD: begin
            v_we        = 1'b1;
            v_wdata     = sat_sum({a_reg[31], a_reg} + {b_reg[31], b_reg});
            vcount_next = vcount_m1;
            ocount_next = ocount_m1;
            state_next  = ST_REDUCE;
          end
          OP_SUB: begin
            v_we        = 1'b1;
            v_wdata     = sat_sum({a_reg[31], a_reg} - {b_reg[31], b_reg});
            vcount_next = vcount_m1;
            ocount_next = ocount_m1;
            state_next  = ST_REDUCE;
          end
          OP_MUL: begin
            prod_next  = a_reg * b_reg;
            state_next = ST_MUL;
          end
          default: begin
            if (b_reg == '0) begin
              // drop the divisor, keep the dividend
              emit_req  = 1'b1;
              emit_kind = KIND_ZERODIV;
              if (!emit_stall) begin
                vcount_next = vcount_m1;
                ocount_next = ocount_m1;
                state_next  = ST_REDUCE;
              end
            end else begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
        endcase
      end
      ST_MUL: begin
        v_we        = 1'b1;
        v_waddr     = vcount_m2[VAW-1:0];
        v_wdata     = mul_scale(prod);
        vcount_next = vcount_m1;
        ocount_next = ocount_m1;
        state_next  = ST_REDUCE;
      end
      ST_DIV: begin
        v_waddr = vcount_m2[VAW-1:0];
        v_wdata = div_quo;
        if (div_done) begin
          v_we        = 1'b1;
          vcount_next = vcount_m1;
          ocount_next = ocount_m1;
          state_next  = ST_REDUCE;
        end
      end
      ST_FINISH: begin
        if (!held_valid) begin
          emit_cnt_next = '0;
          state_next    = ST_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_last       = 1'b1;
          held_valid_next = 1'b0;
          emit_cnt_next   = '0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // results past the limit for one token are dropped
    if (emit_req && !emit_stall && under_limit) begin
      if (held_valid) begin
        push = 1'b1;
      end
      held_valid_next = 1'b1;
      held_kind_next  = emit_kind;
      held_value_next = emit_value;
      emit_cnt_next   = emit_cnt + 1'b1;
    end

    if (push) begin
      out_valid_next    = 1'b1;
      result_kind_next  = held_kind;
      result_value_next = held_value;
      last_of_run_next  = push_last;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      vcount     <= '0;
      ocount     <= '0;
      held_valid <= 1'b0;
      emit_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      vcount     <= vcount_next;
      ocount     <= ocount_next;
      held_valid <= held_valid_next;
      emit_cnt   <= emit_cnt_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_reg       <= op_reg_next;
    a_reg        <= a_reg_next;
    b_reg        <= b_reg_next;
    prod         <= prod_next;
    held_kind    <= held_kind_next;
    held_value   <= held_value_next;
    result_kind  <= result_kind_next;
    result_value <= result_value_next;
    last_of_run  <= last_of_run_next;
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !held_valid && emit_cnt == '0)
    else $error("held result left over between tokens");

  a_last_at_finish: assert property (@(posedge clk) disable iff (rst)
    push && push_last |-> state == ST_FINISH)
    else $error("end-of-run marker outside finish");

  a_reduce_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_REDUCE && ocount == '0 |=> state == ST_FINISH)
    else $error("reduction continued with no pending operator");

  a_depths: assert property (@(posedge clk) disable iff (rst)
    vcount <= VCW'(VALUE_DEPTH) && ocount <= OCW'(OP_DEPTH))
    else $error("stack depth out of range");

endmodule

// ===== rtl/core/prefix_expression_evaluator.sv =====
// Top level of the prefix expression evaluator: front end, command queue, back end.
//
//   channel   direction  transfer when         payload
//   in        input      in_valid & in_ready   req_type, operator_code, number_value
//   out       output     out_valid & out_ready result_kind, result_value, last_of_run
//
// Front end takes one token a cycle into a 4-entry queue while it has room; the back end
// runs one command at a time. Operator and unknown tokens go to finish; end of line first
// reads the stack top unless it is empty. A number is pushed, then each pending operator
// with both operands is reduced: operator read, b and a read in turn on one RAM port,
// execute, and a multiply step or the shared divider (one quotient bit a cycle).
// Synchronous active-high reset empties both stacks; no clearing pass is needed.
// A stalled output holds the back end in the finish step, or at a second result of a
// token, until the output register frees up.
module prefix_expression_evaluator #(
  parameter int VALUE_DEPTH = pxe_pkg::VALUE_DEPTH_DEF,
  parameter int OP_DEPTH    = pxe_pkg::OP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [1:0]         operator_code,
  input  logic signed [31:0] number_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         result_kind,
  output logic signed [31:0] result_value,
  output logic               last_of_run
);
  import pxe_pkg::*;

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  pxe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .operator_code (operator_code),
    .number_value  (number_value),
    .cmd_valid     (fq_valid),
    .cmd_ready     (fq_ready),
    .cmd           (fq_cmd)
  );

  pxe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_cmd)
  );

  pxe_back #(
    .VALUE_DEPTH (VALUE_DEPTH),
    .OP_DEPTH    (OP_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (qb_valid),
    .cmd_ready    (qb_ready),
    .cmd          (qb_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .result_value (result_value),
    .last_of_run  (last_of_run)
  );

endmodule

// ===== test/pxe_checker.sv =====
// Checker for the prefix expression evaluator: predicts results per token and compares.
`timescale 1ns / 1ps

module pxe_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [1:0]         operator_code,
  input  logic signed [31:0] number_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         result_kind,
  input  logic signed [31:0] result_value,
  input  logic               last_of_run,
  output int                 mismatches,
  output int                 awaiting
);
  import pxe_pkg::*;

  localparam int VDEPTH     = VALUE_DEPTH_DEF;
  localparam int ODEPTH     = OP_DEPTH_DEF;
  localparam int PRINT_CAP  = 50;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic               tail;
  } eval_result_t;

  logic signed [31:0] val_stack[VDEPTH];
  int                 val_count;
  logic [1:0]         op_code[ODEPTH];
  int                 op_mark[ODEPTH];
  int                 op_count;

  eval_result_t       awaited[$];
  eval_result_t       token_results[$];

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("ERROR %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic add_result(input logic [2:0] kind, input logic signed [31:0] value);
    if (token_results.size() < RESULT_LIMIT) begin
      token_results.push_back('{kind, value, 1'b0});
    end
  endtask

  // Q16.16 arithmetic, truncating toward zero, saturated to 32 bits
  function automatic logic signed [31:0] fold_value(input logic [1:0] code,
                                                    input longint a, input longint b);
    longint r;
    case (code)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = (a * b) / 65536;
      default: r = (a * 65536) / b;
    endcase
    if (r > longint'(Q_MAX)) begin
      r = longint'(Q_MAX);
    end else if (r < longint'(Q_MIN)) begin
      r = longint'(Q_MIN);
    end
    return r[31:0];
  endfunction

  task automatic stack_push(input logic signed [31:0] v);
    if (val_count >= VDEPTH) begin
      add_result(KIND_FULL, '0);
    end else begin
      val_stack[val_count] = v;
      val_count++;
    end
  endtask

  // apply every pending operator that has both operands, innermost first
  task automatic fold_pending();
    logic [1:0] code;
    longint     a;
    longint     b;
    while (op_count > 0 && op_mark[op_count-1] + 2 <= val_count) begin
      code = op_code[op_count-1];
      b    = val_stack[val_count-1];
      a    = val_stack[val_count-2];
      op_count--;
      if (code == OP_DIV && b == 0) begin
        // divisor dropped, dividend stays
        val_count--;
        add_result(KIND_ZERODIV, '0);
      end else begin
        val_count -= 2;
        stack_push(fold_value(code, a, b));
      end
    end
  endtask

  task automatic evaluate_token(input logic [1:0] tok, input logic [1:0] code,
                                input logic signed [31:0] val);
    token_results.delete();
    case (tok)
      TOK_NUM: begin
        stack_push(val);
        fold_pending();
      end
      TOK_OP: begin
        if (op_count >= ODEPTH) begin
          add_result(KIND_FULL, '0);
        end else begin
          op_code[op_count] = code;
          op_mark[op_count] = val_count;
          op_count++;
        end
      end
      TOK_EOL: begin
        if (val_count == 0) begin
          add_result(KIND_EMPTY, '0);
        end else begin
          val_count--;
          add_result(KIND_VALUE, val_stack[val_count]);
        end
      end
      default: add_result(KIND_UNKNOWN, '0);
    endcase
    if (token_results.size() > 0) begin
      token_results[token_results.size()-1].tail = 1'b1;
    end
    foreach (token_results[i]) begin
      awaited.push_back(token_results[i]);
    end
  endtask

  always @(posedge clk) begin
    eval_result_t want;
    if (rst) begin
      val_count = 0;
      op_count  = 0;
      for (int i = 0; i < VDEPTH; i++) val_stack[i] = '0;
      for (int i = 0; i < ODEPTH; i++) begin
        op_code[i] = '0;
        op_mark[i] = 0;
      end
      awaited.delete();
    end else begin
      if (in_valid && in_ready) begin
        evaluate_token(req_type, operator_code, number_value);
      end
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %0d last %0b",
                                    result_kind, result_value, last_of_run));
        end else begin
          want = awaited.pop_front();
          if (result_kind !== want.kind || result_value !== want.value ||
              last_of_run !== want.tail) begin
            report_mismatch($sformatf(
                "got kind %0d value %0d last %0b, want kind %0d value %0d last %0b",
                result_kind, result_value, last_of_run, want.kind, want.value, want.tail));
          end
        end
      end
    end
    awaiting <= awaited.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the prefix expression evaluator: clock, reset, token stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import pxe_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int TAIL_CYCLES   = 4000;
  localparam int RANDOM_TARGET = 330;
  localparam int FINAL_TARGET  = 370;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type      = '0;
  logic [1:0]         operator_code = '0;
  logic signed [31:0] number_value  = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [2:0]         result_kind;
  logic signed [31:0] result_value;
  logic               last_of_run;

  int errors;
  int awaiting;
  int cycles     = 0;
  int idle_pct   = 0;
  int stall_left = 0;
  int sent       = 0;

  always #6 clk = ~clk;

  prefix_expression_evaluator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .operator_code (operator_code),
    .number_value  (number_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .result_value  (result_value),
    .last_of_run   (last_of_run)
  );

  pxe_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .operator_code (operator_code),
    .number_value  (number_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .result_value  (result_value),
    .last_of_run   (last_of_run),
    .mismatches    (errors),
    .awaiting      (awaiting)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL prefix_expression_evaluator");
      $finish;
    end
  end

  // receiver stalls in bursts of random length, each started with idle_pct percent probability
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [31:0] rand_q();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        k = int'($urandom_range(0, 200)) - 100;
        return k * 65536;
      end
      3, 4: begin
        k = int'($urandom_range(0, 2097152)) - 1048576;
        return k;
      end
      5: return '0;
      6: begin
        case ($urandom_range(0, 3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'h0001_0000;
          default: return 32'hffff_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_token(input logic [1:0] tok, input logic [1:0] code,
                            input logic [31:0] val);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= tok;
    operator_code <= code;
    number_value  <= val;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_num(input logic [31:0] v);
    send_token(TOK_NUM, 2'($urandom), v);
  endtask

  task automatic send_op(input logic [1:0] code);
    send_token(TOK_OP, code, $urandom);
  endtask

  task automatic send_eol();
    send_token(TOK_EOL, 2'($urandom), $urandom);
  endtask

  // well-formed prefix expression: operator count bounded by max_ops
  task automatic send_expr(input int max_ops);
    int need;
    int ops;
    need = 1;
    ops  = 0;
    while (need > 0) begin
      if (ops < max_ops && $urandom_range(0, 99) < 55) begin
        send_op(2'($urandom));
        ops++;
        need++;
      end else begin
        send_num(rand_q());
        need--;
      end
    end
  endtask

  // sender holds off until every predicted result has been seen
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: saturation, rounding, zero divisor, unknown token, empty pop
    idle_pct = 25;
    send_token(TOK_UNK, OP_DIV, 32'hffff_ffff);
    send_op(OP_ADD); send_num(Q_MAX);        send_num(32'h0001_0000);
    send_op(OP_SUB); send_num(Q_MIN);        send_num(32'h0001_0000);
    send_op(OP_MUL); send_num(Q_MAX);        send_num(Q_MAX);
    send_op(OP_DIV); send_num(32'h0005_0000); send_num('0);
    send_op(OP_DIV); send_num(Q_MIN);        send_num(32'hffff_0000);
    send_op(OP_MUL); send_num(-3);           send_num(32'h0000_8000);
    repeat (7) send_eol();
    settle();

    // operator stack overflow, then a long chain of reductions
    idle_pct = 10;
    repeat (OP_DEPTH_DEF + 1) send_op(2'($urandom));
    repeat (OP_DEPTH_DEF + 1) begin
      send_num(($urandom_range(0, 9) < 3) ? 32'h0 : rand_q());
    end
    repeat (2) send_eol();
    settle();

    // value stack overflow, then pop everything and one more
    idle_pct = 35;
    repeat (VALUE_DEPTH_DEF + 1) send_num($urandom);
    repeat (VALUE_DEPTH_DEF + 1) send_eol();
    settle();

    while (sent < RANDOM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 8;
          default: idle_pct = 35;
        endcase
      end
      if ($urandom_range(0, 99) < 12) begin
        send_token(2'($urandom), 2'($urandom), rand_q());
      end else begin
        send_expr($urandom_range(0, 7));
        if ($urandom_range(0, 9) != 0) send_eol();
      end
    end

    // closing stretch at full rate
    idle_pct = 0;
    while (sent < FINAL_TARGET) begin
      send_expr($urandom_range(0, 5));
      send_eol();
    end
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS prefix_expression_evaluator");
    end else begin
      $display("FAIL prefix_expression_evaluator");
    end
    $finish;
  end

endmodule
